// ===== rtl/core/u2a_pkg.sv =====
package u2a_pkg;

   // Most characters one input byte can produce
   localparam int MAX_CHARS = 4;

   localparam logic [6:0] CHAR_QMARK = 7'h3F;
   localparam logic [6:0] CHAR_SPACE = 7'h20;
   localparam logic [6:0] CHAR_DEL   = 7'h7F;

   // Folded replacement of one code point: one to three characters
   typedef struct packed {
      logic [1:0]      len;
      logic [2:0][6:0] chars;
   } fold_type;

   // Characters produced by one transaction, as they travel front to back
   typedef struct packed {
      logic [MAX_CHARS-1:0][6:0] chars;
      logic [2:0]                count;
      logic                      eos;
   } group_type;

   function automatic fold_type fold1(logic [7:0] c0);
      fold_type f;
      f.len   = 2'd1;
      f.chars = {CHAR_QMARK, CHAR_QMARK, c0[6:0]};
      return f;
   endfunction

   function automatic fold_type fold2(logic [7:0] c0, logic [7:0] c1);
      fold_type f;
      f.len   = 2'd2;
      f.chars = {CHAR_QMARK, c1[6:0], c0[6:0]};
      return f;
   endfunction

   function automatic fold_type fold3(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
      fold_type f;
      f.len   = 2'd3;
      f.chars = {c2[6:0], c1[6:0], c0[6:0]};
      return f;
   endfunction

   // Fold a code point to ASCII; Latin-1 letters, some Latin Extended-A letters and a few marks, else '?'
   function automatic fold_type fold_code_point(logic [20:0] cp);
      fold_type f;
      unique case (cp) inside
         [21'h0C0:21'h0C5]: f = fold1("A");
         21'h0C6:           f = fold2("A", "E");
         21'h0C7:           f = fold1("C");
         [21'h0C8:21'h0CB]: f = fold1("E");
         [21'h0CC:21'h0CF]: f = fold1("I");
         21'h0D0:           f = fold1("D");
         21'h0D1:           f = fold1("N");
         [21'h0D2:21'h0D6]: f = fold1("O");
         21'h0D7:           f = fold1("x");
         21'h0D8:           f = fold1("O");
         [21'h0D9:21'h0DC]: f = fold1("U");
         21'h0DD:           f = fold1("Y");
         21'h0DE:           f = fold2("T", "h");
         21'h0DF:           f = fold2("s", "s");
         [21'h0E0:21'h0E5]: f = fold1("a");
         21'h0E6:           f = fold2("a", "e");
         21'h0E7:           f = fold1("c");
         [21'h0E8:21'h0EB]: f = fold1("e");
         [21'h0EC:21'h0EF]: f = fold1("i");
         21'h0F0:           f = fold1("d");
         21'h0F1:           f = fold1("n");
         [21'h0F2:21'h0F6]: f = fold1("o");
         21'h0F7:           f = fold1("/");
         21'h0F8:           f = fold1("o");
         [21'h0F9:21'h0FC]: f = fold1("u");
         21'h0FD:           f = fold1("y");
         21'h0FE:           f = fold2("t", "h");
         21'h0FF:           f = fold1("y");
         21'h0A0:           f = fold1(" ");
         21'h2018, 21'h2019, 21'h0B4: f = fold1("'");
         21'h201C, 21'h201D, 21'h0AB, 21'h0BB: f = fold1("\"");
         21'h2010, 21'h2013, 21'h2014: f = fold1("-");
         21'h2026:          f = fold3(".", ".", ".");
         21'h0152:          f = fold2("O", "E");
         21'h0153:          f = fold2("o", "e");
         21'h0160:          f = fold1("S");
         21'h0161:          f = fold1("s");
         21'h017D:          f = fold1("Z");
         21'h017E:          f = fold1("z");
         default:           f = fold1("?");
      endcase
      return f;
   endfunction

endpackage

// ===== rtl/core/u2a_channels.sv =====
// Byte stream into the folder
interface u2a_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// Folded ASCII characters out of the folder
interface u2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       run_last;
   logic       text_last;

   modport source (output valid, output out_char, output run_last, output text_last,
                   input ready);
   modport sink   (input valid, input out_char, input run_last, input text_last,
                   output ready);
endinterface

// ===== rtl/core/u2a_front.sv =====
module u2a_front (
   input  logic              clock,
   input  logic              reset,
   u2a_req_if.sink           req_bus,
   input  logic              push_ready,
   output logic              push_valid,
   output u2a_pkg::group_type push_group
);
   import u2a_pkg::*;

   // Decode state of the open sequence
   logic [1:0]  expected_ff, expected_in;
   logic [1:0]  absorbed_ff, absorbed_in;
   logic [20:0] acc_ff, acc_in;

   logic             req_fire;
   logic             is_cont;
   logic             seq_open;
   logic [20:0]      acc_next;
   logic [1:0]       absorbed_next;
   fold_type         fold_res;
   logic [1:0]       n_flush;     // '?' for a broken sequence
   logic [1:0]       n_body;      // characters from this byte itself
   logic [1:0]       n_tail;      // '?' for a sequence cut by end of string
   logic [3:0][6:0]  body_chars;
   logic [3:0]       total;
   logic [2:0]       slot_rel [MAX_CHARS];

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = push_ready;
   assign is_cont       = (req_bus.in_byte[7:6] == 2'b10);
   assign seq_open      = (expected_ff != 2'd0);
   assign acc_next      = {acc_ff[14:0], req_bus.in_byte[5:0]};
   assign absorbed_next = absorbed_ff + 2'd1;
   assign fold_res      = fold_code_point(acc_next);

   // Classify the byte and work out the next decode state
   always_comb begin
      expected_in = expected_ff;
      absorbed_in = absorbed_ff;
      acc_in      = acc_ff;
      n_flush     = 2'd0;
      n_body      = 2'd0;
      n_tail      = 2'd0;
      body_chars  = {MAX_CHARS{CHAR_QMARK}};
      if (seq_open && is_cont) begin
         if (absorbed_next >= expected_ff) begin
            // sequence complete: fold the code point
            n_body          = fold_res.len;
            body_chars[2:0] = fold_res.chars;
            expected_in     = 2'd0;
            absorbed_in     = 2'd0;
            acc_in          = '0;
         end else begin
            absorbed_in = absorbed_next;
            acc_in      = acc_next;
         end
      end else begin
         if (seq_open) begin
            n_flush = 2'd1 + absorbed_ff;
         end
         expected_in = 2'd0;
         absorbed_in = 2'd0;
         acc_in      = '0;
         if (!req_bus.in_byte[7]) begin
            n_body = 2'd1;
            if (req_bus.in_byte[6:0] < CHAR_SPACE || req_bus.in_byte[6:0] == CHAR_DEL) begin
               body_chars[0] = CHAR_SPACE;
            end else begin
               body_chars[0] = req_bus.in_byte[6:0];
            end
         end else if (!req_bus.in_byte[6]) begin
            // stray continuation byte
            n_body = 2'd1;
         end else if (req_bus.in_byte[5:4] == 2'b11) begin
            expected_in = 2'd3;
            acc_in      = {18'd0, req_bus.in_byte[2:0]};
         end else if (req_bus.in_byte[5]) begin
            expected_in = 2'd2;
            acc_in      = {17'd0, req_bus.in_byte[3:0]};
         end else begin
            expected_in = 2'd1;
            acc_in      = {16'd0, req_bus.in_byte[4:0]};
         end
      end
      // end of string flushes whatever is still open
      if (req_bus.end_of_string && expected_in != 2'd0) begin
         n_tail      = 2'd1 + absorbed_in;
         expected_in = 2'd0;
         absorbed_in = 2'd0;
         acc_in      = '0;
      end
   end

   // Lay the characters out: flush '?', byte characters, tail '?'
   assign total = 4'(n_flush) + 4'(n_body) + 4'(n_tail);

   always_comb begin
      push_group.count = (total > 4'(MAX_CHARS)) ? 3'(MAX_CHARS) : total[2:0];
      push_group.eos   = req_bus.end_of_string;
      for (int i = 0; i < MAX_CHARS; i++) begin
         slot_rel[i] = 3'(i) - 3'(n_flush);
         if (3'(i) < 3'(n_flush)) begin
            push_group.chars[i] = CHAR_QMARK;
         end else if (slot_rel[i] < 3'(n_body)) begin
            push_group.chars[i] = body_chars[slot_rel[i][1:0]];
         end else begin
            push_group.chars[i] = CHAR_QMARK;
         end
      end
   end

   assign push_valid = req_bus.valid && (total != 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= 2'd0;
         absorbed_ff <= 2'd0;
         acc_ff      <= '0;
      end else if (req_fire) begin
         expected_ff <= expected_in;
         absorbed_ff <= absorbed_in;
         acc_ff      <= acc_in;
      end
   end

   a_absorbed_below_expected: assert property (@(posedge clock) disable iff (reset)
      (expected_ff != 2'd0) |-> (absorbed_ff < expected_ff))
      else $error("absorbed count reached expected count without closing");

   a_idle_state_clear: assert property (@(posedge clock) disable iff (reset)
      (expected_ff == 2'd0) |-> (absorbed_ff == 2'd0 && acc_ff == 21'd0))
      else $error("decode state not cleared with no open sequence");

   a_eos_closes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.end_of_string) |=> (expected_ff == 2'd0))
      else $error("sequence left open after end of string");

endmodule

// ===== rtl/core/u2a_queue.sv =====
module u2a_queue #(
   parameter int Depth = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  u2a_pkg::group_type push_group,
   output logic               push_ready,
   output logic               pop_valid,
   output u2a_pkg::group_type pop_group,
   input  logic               pop_ready
);
   import u2a_pkg::*;

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   group_type               entries_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    push_fire;
   logic                    pop_fire;

   assign push_ready = (count_ff != CountWidth'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_group  = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_group;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Depth))
      else $error("queue fill count beyond depth");

   a_empty_pointers_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("empty queue with pointers apart");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push without pop did not grow the queue");

endmodule

// ===== rtl/core/u2a_back.sv =====
module u2a_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  u2a_pkg::group_type pop_group,
   output logic               pop_ready,
   u2a_rsp_if.source          rsp_bus
);
   import u2a_pkg::*;

   // Position of the next character within the head group
   logic [1:0] idx_ff, idx_in;
   logic       last_char;
   logic       rsp_fire;

   assign last_char         = ({1'b0, idx_ff} == pop_group.count - 3'd1);
   assign rsp_fire          = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid     = pop_valid;
   assign rsp_bus.out_char  = pop_group.chars[idx_ff];
   assign rsp_bus.run_last  = last_char;
   assign rsp_bus.text_last = last_char && pop_group.eos;
   assign pop_ready         = rsp_bus.ready && last_char;

   // Step through the group, retire it with its last character
   always_comb begin
      idx_in = idx_ff;
      if (rsp_fire) begin
         idx_in = last_char ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== rtl/core/utf8_to_ascii_folder_unit.sv =====
// UTF-8 to printable ASCII folder. Bytes enter on req_bus one per transaction;
// folded characters leave on rsp_bus, zero to four per byte, with run_last on
// the final character of each byte and text_last on the final character of a
// string. The front decodes a byte in the cycle it is accepted and hands its
// characters as one group to a queue of QueueDepth groups; the back sends one
// character per cycle from the queue head while rsp_bus.ready is high, so the
// sustained rate is set by the output port. A byte's characters are registered
// in the queue before the back sends them. The input keeps taking bytes while
// the queue has room, also while the output stalls.
module utf8_to_ascii_folder_unit #(
   parameter int QueueDepth = 4
) (
   input  logic      clock,
   input  logic      reset,
   u2a_req_if.sink   req_bus,
   u2a_rsp_if.source rsp_bus
);
   import u2a_pkg::*;

   logic      push_valid;
   logic      push_ready;
   group_type push_group;
   logic      pop_valid;
   logic      pop_ready;
   group_type pop_group;

   u2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_group (push_group)
   );

   u2a_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_group (push_group),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_group  (pop_group),
      .pop_ready  (pop_ready)
   );

   u2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_group (pop_group),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== dv/utf8_to_ascii_folder_unit_tb.sv =====
`timescale 1ns / 100ps

module utf8_to_ascii_folder_unit_tb;
   import u2a_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 60;
   localparam int RANDOM_ITEMS = 80;
   localparam int MAX_REPORTS  = 40;

   // UTF-8 byte classes
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;
   localparam logic [7:0] LEAD2     = 8'hC0;
   localparam logic [7:0] LEAD3     = 8'hE0;
   localparam logic [7:0] LEAD4     = 8'hF0;

   typedef struct packed {
      logic [6:0] ch;
      logic       run_last;
      logic       text_last;
   } ascii_char_type;

   logic clock;
   logic reset;

   u2a_req_if req_bus ();
   u2a_rsp_if rsp_bus ();

   utf8_to_ascii_folder_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Decoder state mirrored from the block, and the characters still owed
   logic [1:0]     open_need  = '0;
   logic [1:0]     open_taken = '0;
   logic [20:0]    open_cp    = '0;
   logic [6:0]     byte_chars[$];
   ascii_char_type ascii_due[$];

   int unsigned mismatches = 0;
   int unsigned burst_left = 0;
   bit          gaps_on    = 1'b1;
   bit          hold_request = 1'b0;

   // ASCII spelling of U+00C0..U+00FF
   function automatic string latin1_letter(logic [5:0] idx);
      string s;
      case (idx)
         6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05:  s = "A";
         6'h06:                                     s = "AE";
         6'h07:                                     s = "C";
         6'h08, 6'h09, 6'h0A, 6'h0B:                s = "E";
         6'h0C, 6'h0D, 6'h0E, 6'h0F:                s = "I";
         6'h10:                                     s = "D";
         6'h11:                                     s = "N";
         6'h12, 6'h13, 6'h14, 6'h15, 6'h16, 6'h18:  s = "O";
         6'h17:                                     s = "x";
         6'h19, 6'h1A, 6'h1B, 6'h1C:                s = "U";
         6'h1D:                                     s = "Y";
         6'h1E:                                     s = "Th";
         6'h1F:                                     s = "ss";
         6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25:  s = "a";
         6'h26:                                     s = "ae";
         6'h27:                                     s = "c";
         6'h28, 6'h29, 6'h2A, 6'h2B:                s = "e";
         6'h2C, 6'h2D, 6'h2E, 6'h2F:                s = "i";
         6'h30:                                     s = "d";
         6'h31:                                     s = "n";
         6'h32, 6'h33, 6'h34, 6'h35, 6'h36, 6'h38:  s = "o";
         6'h37:                                     s = "/";
         6'h39, 6'h3A, 6'h3B, 6'h3C:                s = "u";
         6'h3E:                                     s = "th";
         default:                                   s = "y";
      endcase
      return s;
   endfunction

   function automatic string ascii_for_cp(logic [20:0] cp);
      string s;
      if (cp >= 21'h0C0 && cp <= 21'h0FF) begin
         s = latin1_letter(cp[5:0]);
      end else begin
         case (cp)
            21'h0A0:                              s = " ";
            21'h2018, 21'h2019, 21'h0B4:          s = "'";
            21'h201C, 21'h201D, 21'h0AB, 21'h0BB: s = "\"";
            21'h2010, 21'h2013, 21'h2014:         s = "-";
            21'h2026:                             s = "...";
            21'h0152:                             s = "OE";
            21'h0153:                             s = "oe";
            21'h0160:                             s = "S";
            21'h0161:                             s = "s";
            21'h017D:                             s = "Z";
            21'h017E:                             s = "z";
            default:                              s = "?";
         endcase
      end
      return s;
   endfunction

   function automatic void emit_char(logic [6:0] c);
      if (byte_chars.size() < MAX_CHARS) byte_chars.push_back(c);
   endfunction

   function automatic void emit_text(string s);
      byte c;
      for (int k = 0; k < s.len(); k++) begin
         c = s.getc(k);
         emit_char(c[6:0]);
      end
   endfunction

   function automatic void clear_open();
      open_need  = '0;
      open_taken = '0;
      open_cp    = '0;
   endfunction

   // One '?' for the lead plus one per continuation taken
   function automatic void abandon_seq();
      for (int k = 0; k <= open_taken; k++) emit_char(CHAR_QMARK);
      clear_open();
   endfunction

   function automatic void take_fresh(logic [7:0] b);
      if (b < CONT_TAG) begin
         emit_char((b < 8'h20 || b == {1'b0, CHAR_DEL}) ? CHAR_SPACE : b[6:0]);
      end else if (b < LEAD2) begin
         emit_char(CHAR_QMARK);
      end else begin
         open_need  = (b >= LEAD4) ? 2'd3 : (b >= LEAD3) ? 2'd2 : 2'd1;
         open_taken = '0;
         open_cp    = {13'd0, b & (8'h3F >> open_need)};
      end
   endfunction

   // Works out the characters one accepted byte owes and queues them
   function automatic void fold_byte(logic [7:0] b, logic eos);
      logic [20:0]    cp;
      ascii_char_type r;
      byte_chars.delete();
      if (open_need != 0) begin
         if ((b & CONT_MASK) == CONT_TAG) begin
            open_cp    = {open_cp[14:0], b[5:0]};
            open_taken = open_taken + 2'd1;
            if (open_taken >= open_need) begin
               cp = open_cp;
               clear_open();
               emit_text(ascii_for_cp(cp));
            end
         end else begin
            abandon_seq();
            take_fresh(b);
         end
      end else begin
         take_fresh(b);
      end
      // end of string flushes whatever is still open
      if (eos && open_need != 0) abandon_seq();
      foreach (byte_chars[k]) begin
         r.ch        = byte_chars[k];
         r.run_last  = (k == byte_chars.size() - 1);
         r.text_last = eos && r.run_last;
         ascii_due.push_back(r);
      end
   endfunction

   // Sender: bursts of random length with random gaps in between
   task automatic send_byte(input logic [7:0] b, input logic eos);
      if (gaps_on && burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(1, 8);
      end
      if (burst_left != 0) burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.in_byte       <= b;
      req_bus.end_of_string <= eos;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      fold_byte(b, eos);
   endtask

   // Stop offering and wait for every owed character
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (ascii_due.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // One random piece of text: mostly well-formed, some stray and broken bytes
   task automatic send_random_text_unit(output int unsigned sent);
      logic [7:0]  seq[$];
      logic [7:0]  lead;
      int unsigned need;
      bit          ragged;
      ragged = 1'b0;
      case ($urandom_range(0, 10))
         0, 1, 2, 3: seq.push_back(8'($urandom_range(0, 127)));
         4, 5, 6, 7: begin
            case ($urandom_range(0, 4))
               0: begin
                  seq.push_back(8'hC3);
                  seq.push_back(8'h80 + 8'($urandom_range(0, 63)));
               end
               1: begin
                  seq.push_back(8'hC2);
                  seq.push_back(8'h80 + 8'($urandom_range(0, 63)));
               end
               2: begin
                  seq.push_back(8'hC5);
                  case ($urandom_range(0, 6))
                     0: seq.push_back(8'h92);
                     1: seq.push_back(8'h93);
                     2: seq.push_back(8'hA0);
                     3: seq.push_back(8'hA1);
                     4: seq.push_back(8'hBD);
                     5: seq.push_back(8'hBE);
                     default: seq.push_back(8'h80 + 8'($urandom_range(0, 63)));
                  endcase
               end
               3: begin
                  seq.push_back(8'hE2);
                  seq.push_back(8'h80);
                  case ($urandom_range(0, 8))
                     0: seq.push_back(8'h90);
                     1: seq.push_back(8'h93);
                     2: seq.push_back(8'h94);
                     3: seq.push_back(8'h98);
                     4: seq.push_back(8'h99);
                     5: seq.push_back(8'h9C);
                     6: seq.push_back(8'h9D);
                     7: seq.push_back(8'hA6);
                     default: seq.push_back(8'h80 + 8'($urandom_range(0, 63)));
                  endcase
               end
               default: begin
                  lead = 8'($urandom_range(8'hC0, 8'hFF));
                  need = (lead >= LEAD4) ? 3 : (lead >= LEAD3) ? 2 : 1;
                  seq.push_back(lead);
                  repeat (need) seq.push_back(8'h80 + 8'($urandom_range(0, 63)));
               end
            endcase
         end
         8: seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
         9: begin
            // truncated sequence cut by a non-continuation byte
            lead = 8'($urandom_range(8'hC0, 8'hFF));
            need = (lead >= LEAD4) ? 3 : (lead >= LEAD3) ? 2 : 1;
            seq.push_back(lead);
            repeat ($urandom_range(0, need - 1))
               seq.push_back(8'h80 + 8'($urandom_range(0, 63)));
            if ($urandom_range(0, 1) == 0) seq.push_back(8'($urandom_range(0, 127)));
            else seq.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            ragged = 1'b1;
         end
         default: begin
            seq.push_back(8'($urandom_range(0, 255)));
            ragged = 1'b1;
         end
      endcase
      foreach (seq[k]) begin
         send_byte(seq[k],
                   (ragged || k == seq.size() - 1) ? ($urandom_range(0, 15) == 0) : 1'b0);
      end
      sent = seq.size();
   endtask

   // Control bytes and DEL become space, printable ASCII passes
   task automatic test_ascii_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'h1F, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h7F, 1'b0);
   endtask

   // Multi-character folds of two- and three-byte sequences
   task automatic test_multi_char_folds();
      send_byte(8'hC3, 1'b0);
      send_byte(8'h86, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hA6, 1'b0);
      send_byte(8'hC5, 1'b0);
      send_byte(8'h92, 1'b0);
   endtask

   // Overlong form of 'A', and a 0xF8 lead taken as a four-byte lead
   task automatic test_overlong_and_wide_leads();
      send_byte(8'hC1, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
   endtask

   // Stray continuation, and a sequence broken by a plain ASCII byte
   task automatic test_stray_and_broken();
      send_byte(8'hBF, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h41, 1'b0);
   endtask

   // End of string on ASCII, and on a breaking lead that is flushed too (four chars)
   task automatic test_end_of_string();
      send_byte(8'h41, 1'b1);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hC3, 1'b1);
   endtask

   // Receiver holds off while the sender keeps going, so the block stalls its input
   task automatic test_output_backpressure();
      int unsigned n;
      gaps_on      = 1'b0;
      hold_request = 1'b1;
      repeat (10) send_random_text_unit(n);
      gaps_on = 1'b1;
   endtask

   task automatic test_random_text();
      int unsigned total;
      int unsigned n;
      total = 0;
      while (total < RANDOM_ITEMS) begin
         send_random_text_unit(n);
         total += n;
         if ($urandom_range(0, 19) == 0) gaps_on = ~gaps_on;
      end
      gaps_on = 1'b1;
   endtask

   // Receiver: stall rate changes over spans of random length, plus long holds
   int unsigned hold_left  = 0;
   int unsigned stall_pct  = 0;
   int unsigned stall_span = 0;

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (stall_span == 0) begin
         stall_span = $urandom_range(16, 64);
         case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 50;
            default: stall_pct = 85;
         endcase
      end
      stall_span--;
      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   // Each output transaction against the oldest owed character
   always @(posedge clock) begin : rsp_check
      ascii_char_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (ascii_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual %h/%b/%b", $time,
                        rsp_bus.out_char, rsp_bus.run_last, rsp_bus.text_last);
         end else begin
            want = ascii_due.pop_front();
            check_field("out_char", want.ch, rsp_bus.out_char);
            check_field("run_last", {6'd0, want.run_last}, {6'd0, rsp_bus.run_last});
            check_field("text_last", {6'd0, want.text_last}, {6'd0, rsp_bus.text_last});
         end
      end
   end

   // Watchdog on cycles without any transaction
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("utf8_to_ascii_folder_unit_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.in_byte       <= 8'h00;
      req_bus.end_of_string <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_ascii_bytes();
      test_multi_char_folds();
      test_overlong_and_wide_leads();
      test_stray_and_broken();
      test_end_of_string();
      drain_results();
      test_output_backpressure();
      drain_results();
      test_random_text();
      drain_results();

      // catch anything extra the block might still send
      repeat (8) @(posedge clock);
      if (mismatches == 0 && ascii_due.size() == 0) begin
         $display("utf8_to_ascii_folder_unit_tb: done, clean");
      end else begin
         $display("utf8_to_ascii_folder_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/u2a_pkg.sv
rtl/core/u2a_channels.sv
rtl/core/u2a_front.sv
rtl/core/u2a_queue.sv
rtl/core/u2a_back.sv
rtl/core/utf8_to_ascii_folder_unit.sv
dv/utf8_to_ascii_folder_unit_tb.sv
